// File: rtl/input_action_dead_zone_combiner_unit_defines.svh
// assertion macros used by iadz_back
`ifndef INPUT_ACTION_DEAD_ZONE_COMBINER_UNIT_DEFINES_SVH
`define INPUT_ACTION_DEAD_ZONE_COMBINER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define IADZ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define IADZ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/iadz_pkg.sv
package iadz_pkg;

	localparam int ActionCountDef = 64;
	localparam int IdxW = 6;

	localparam logic [1:0] KIND_BUTTON = 2'd0;
	localparam logic [1:0] KIND_AXIS   = 2'd1;
	localparam logic [1:0] KIND_VECTOR = 2'd2;
	localparam logic [1:0] KIND_PASS   = 2'd3;

	localparam logic [1:0] SRC_NONE    = 2'd0;
	localparam logic [1:0] SRC_DIGITAL = 2'd1;
	localparam logic [1:0] SRC_ANALOG  = 2'd2;
	localparam logic [1:0] SRC_STICK   = 2'd3;

	localparam logic [2:0] DIR_POS   = 3'd0;
	localparam logic [2:0] DIR_NEG   = 3'd1;
	localparam logic [2:0] DIR_UP    = 3'd2;
	localparam logic [2:0] DIR_DOWN  = 3'd3;
	localparam logic [2:0] DIR_LEFT  = 3'd4;
	localparam logic [2:0] DIR_RIGHT = 3'd5;

	localparam logic [14:0] DZ_MAX = 15'd32440;
	localparam logic signed [23:0] SUM_MAX = 24'sh7fffff;
	localparam logic signed [23:0] SUM_MIN = -24'sh800000;

	typedef struct packed {
		logic [5:0]         action_index;
		logic [1:0]         action_kind;
		logic [14:0]        dead_zone;
		logic               active;
		logic [1:0]         source_kind;
		logic signed [15:0] value_x;
		logic signed [15:0] value_y;
		logic [2:0]         direction;
		logic               last_binding;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         result_action;
		logic               is_down;
		logic               went_down;
		logic               went_up;
		logic signed [15:0] axis_value;
		logic signed [15:0] vector_x;
		logic signed [15:0] vector_y;
	} out_item_t;

	// finished sums handed from front to back
	typedef struct packed {
		logic [5:0]         idx;
		logic [1:0]         kind;
		logic [14:0]        dz;
		logic               down;
		logic signed [23:0] axis;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
	} job_t;

	function automatic logic signed [23:0] sat_add(logic signed [23:0] a,
			logic signed [17:0] b);
		logic signed [24:0] s;
		s = 25'(a) + 25'(b);
		if (s > 25'(SUM_MAX)) return SUM_MAX;
		if (s < 25'(SUM_MIN)) return SUM_MIN;
		return s[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(logic signed [24:0] v);
		if (v > 25'sd32767) return 16'sh7fff;
		if (v < -25'sd32768) return -16'sh8000;
		return v[15:0];
	endfunction

endpackage

// File: rtl/iadz_front.sv
module iadz_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  iadz_pkg::in_item_t in_item,
	output logic             job_valid,
	input  logic             job_stall,
	output iadz_pkg::job_t   job
);
	import iadz_pkg::*;

	logic               sum_down_q;
	logic signed [23:0] sum_axis_q, sum_vx_q, sum_vy_q;
	logic               full_q;
	job_t               job_q;

	logic               acc, dn;
	logic signed [17:0] add_a, add_x, add_y;
	logic signed [23:0] n_axis, n_vx, n_vy;
	logic               n_down;
	logic [31:0]        m2;
	logic signed [16:0] vx17, vy17, ab;
	logic               neg, vert;

	assign in_stall = full_q && in_item.last_binding;
	assign job_valid = full_q;
	assign job = job_q;

	// classify one sample into sum increments
	always_comb begin
		vx17 = 17'(in_item.value_x);
		vy17 = 17'(in_item.value_y);
		neg  = (in_item.direction == DIR_NEG) || (in_item.direction == DIR_DOWN) ||
			(in_item.direction == DIR_LEFT);
		vert = (in_item.direction == DIR_UP) || (in_item.direction == DIR_DOWN);
		acc  = in_item.active && (in_item.source_kind != SRC_NONE);
		m2   = 32'($signed(vx17) * $signed(vx17)) + 32'($signed(vy17) * $signed(vy17));
		ab   = vx17[16] ? -vx17 : vx17;
		dn   = 1'b0;
		add_a = '0;
		add_x = '0;
		add_y = '0;
		case (in_item.source_kind)
			SRC_STICK: begin
				dn    = m2 >= 32'd268435456;
				add_a = neg ? -18'(vert ? vy17 : vx17) : 18'(vert ? vy17 : vx17);
				add_x = 18'(vx17);
				add_y = 18'(vy17);
			end
			default: begin
				dn    = (in_item.source_kind == SRC_ANALOG) ? (ab >= 17'sd16384)
					: (in_item.value_x > 16'sd0);
				add_a = neg ? -18'(vx17) : 18'(vx17);
				if (in_item.direction == DIR_UP) add_y = 18'(vx17);
				else if (in_item.direction == DIR_DOWN) add_y = -18'(vx17);
				else if ((in_item.direction == DIR_NEG) || (in_item.direction == DIR_LEFT))
					add_x = -18'(vx17);
				else add_x = 18'(vx17);
			end
		endcase
		if (!acc) begin
			dn = 1'b0;
			add_a = '0;
			add_x = '0;
			add_y = '0;
		end
		n_down = sum_down_q | dn;
		n_axis = sat_add(sum_axis_q, add_a);
		n_vx   = sat_add(sum_vx_q, add_x);
		n_vy   = sat_add(sum_vy_q, add_y);
	end

	// running sums and one-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_down_q <= 1'b0;
			sum_axis_q <= '0;
			sum_vx_q   <= '0;
			sum_vy_q   <= '0;
			full_q     <= 1'b0;
		end else begin
			if (full_q && !job_stall) full_q <= 1'b0;
			if (in_valid && !in_stall) begin
				if (in_item.last_binding) begin
					sum_down_q <= 1'b0;
					sum_axis_q <= '0;
					sum_vx_q   <= '0;
					sum_vy_q   <= '0;
					full_q     <= 1'b1;
				end else begin
					sum_down_q <= n_down;
					sum_axis_q <= n_axis;
					sum_vx_q   <= n_vx;
					sum_vy_q   <= n_vy;
				end
			end
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall && in_item.last_binding) begin
			job_q.idx  <= in_item.action_index;
			job_q.kind <= in_item.action_kind;
			job_q.dz   <= (in_item.dead_zone > DZ_MAX) ? DZ_MAX : in_item.dead_zone;
			job_q.down <= n_down;
			job_q.axis <= n_axis;
			job_q.vx   <= n_vx;
			job_q.vy   <= n_vy;
		end
	end
endmodule

// File: rtl/iadz_back.sv
module iadz_back #(
	parameter int ACTION_COUNT = iadz_pkg::ActionCountDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_stall,
	input  iadz_pkg::job_t     job,
	output logic               out_valid,
	input  logic               out_stall,
	output iadz_pkg::out_item_t out_item
);
	import iadz_pkg::*;
	`include "input_action_dead_zone_combiner_unit_defines.svh"

	localparam int AW = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQRT = 3'd1;
	localparam logic [2:0] ST_DIV1 = 3'd2;
	localparam logic [2:0] ST_DIV2 = 3'd3;
	localparam logic [2:0] ST_DIV3 = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]         st_q;
	job_t               j_q;
	logic [4:0]         cnt_q;
	// square root
	logic [47:0]        rem_q;
	logic [23:0]        root_q;
	logic [47:0]        sq_n_q;
	// divider
	logic [47:0]        num_q;
	logic [32:0]        den_q;
	logic [47:0]        quo_q;
	logic [5:0]         dcnt_q;
	logic [16:0]        amt_q;
	logic [24:0]        len_q;
	logic [15:0]        mx_q, my_q;
	// previous-down store and its clearing pass
	logic               prev_mem [ACTION_COUNT];
	logic               prev_rd_q;
	logic               clr_busy_q;
	logic [AW-1:0]      clr_idx_q;
	out_item_t          out_q;
	logic               ovalid_q;

	logic [23:0]        ax_abs, xa, ya, lcl;
	logic [47:0]        trial;
	logic [48:0]        dtrial;
	logic               down_n, prev_rd, in_rng, fire;
	logic [AW-1:0]      pidx;
	logic signed [24:0] ox, oy, oa;
	logic [47:0]        quo_n, rem_n;

	assign job_stall = (st_q != ST_IDLE) || clr_busy_q;
	assign out_valid = ovalid_q;
	assign out_item  = out_q;

	always_comb begin
		ax_abs = j_q.axis[23] ? 24'(-j_q.axis) : 24'(j_q.axis);
		xa     = j_q.vx[23] ? 24'(-j_q.vx) : 24'(j_q.vx);
		ya     = j_q.vy[23] ? 24'(-j_q.vy) : 24'(j_q.vy);
		lcl    = (len_q > 25'd32768) ? 24'd32768 : len_q[23:0];
		trial  = {rem_q[45:0], sq_n_q[47:46]};
		// restoring divide step: shift in the next numerator bit, try the subtract
		dtrial = {rem_q, num_q[47]} - 49'(den_q);
		quo_n  = {quo_q[46:0], !dtrial[48]};
		rem_n  = dtrial[48] ? {rem_q[46:0], num_q[47]} : dtrial[47:0];
		in_rng = 32'(j_q.idx) < 32'(ACTION_COUNT);
		pidx   = AW'(j_q.idx);
		fire   = (st_q == ST_DONE) && (!ovalid_q || !out_stall);
	end

	// shift-subtract unit state machine: sqrt for vectors, then up to three divides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			ovalid_q   <= 1'b0;
			cnt_q      <= '0;
			dcnt_q     <= '0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			// walk the store once after reset
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if (clr_idx_q == AW'(ACTION_COUNT - 1)) clr_busy_q <= 1'b0;
			end
			if (fire) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (job_valid && !clr_busy_q) begin
						j_q    <= job;
						rem_q  <= '0;
						root_q <= '0;
						sq_n_q <= 48'(job.vx * job.vx) + 48'(job.vy * job.vy);
						cnt_q  <= '0;
						st_q   <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					// magnitude root, two bits of the radicand a cycle
					if (j_q.kind == KIND_VECTOR) begin
						sq_n_q <= {sq_n_q[45:0], 2'b00};
						if ({trial} >= {root_q[22:0], 2'b01} + 48'd0) begin
							rem_q  <= trial - 48'({root_q, 2'b01});
							root_q <= {root_q[22:0], 1'b1};
						end else begin
							rem_q  <= trial;
							root_q <= {root_q[22:0], 1'b0};
						end
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == 5'd23) st_q <= ST_DIV1;
					end else begin
						st_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					len_q <= (j_q.kind == KIND_VECTOR) ? 25'(root_q) : 25'(ax_abs);
					st_q  <= ST_DIV2;
					dcnt_q <= '0;
				end
				ST_DIV2: begin
					// dead-zone rescale: (a - dz) * 32768 / (32768 - dz)
					if (dcnt_q == 6'd0) begin
						if (lcl <= 24'(j_q.dz)) begin
							amt_q <= '0;
							st_q  <= ST_DIV3;
						end else begin
							num_q  <= 48'(lcl - 24'(j_q.dz)) << 15;
							den_q  <= 33'(17'd32768 - 17'(j_q.dz));
							rem_q  <= '0;
							quo_q  <= '0;
							dcnt_q <= 6'd1;
						end
					end else begin
						rem_q <= rem_n;
						quo_q <= quo_n;
						num_q <= {num_q[46:0], 1'b0};
						if (dcnt_q == 6'd48) begin
							amt_q  <= (quo_n > 48'd32768) ? 17'd32768 : quo_n[16:0];
							st_q   <= ST_DIV3;
							dcnt_q <= '0;
						end else begin
							dcnt_q <= dcnt_q + 6'd1;
						end
					end
				end
				ST_DIV3: begin
					// component scale: |c| * amt / len, x then y
					if (j_q.kind != KIND_VECTOR || len_q == '0) begin
						mx_q <= '0;
						my_q <= '0;
						st_q <= ST_DONE;
					end else if (dcnt_q == 6'd0) begin
						num_q  <= 48'(xa) * 48'(amt_q);
						den_q  <= 33'(len_q);
						rem_q  <= '0;
						quo_q  <= '0;
						dcnt_q <= 6'd1;
						cnt_q  <= '0;
					end else if (dcnt_q == 6'd48 && cnt_q == 5'd0) begin
						mx_q   <= quo_n[15:0];
						num_q  <= 48'(ya) * 48'(amt_q);
						rem_q  <= '0;
						quo_q  <= '0;
						dcnt_q <= 6'd1;
						cnt_q  <= 5'd1;
					end else if (dcnt_q == 6'd48) begin
						my_q <= quo_n[15:0];
						st_q <= ST_DONE;
					end else begin
						rem_q  <= rem_n;
						quo_q  <= quo_n;
						num_q  <= {num_q[46:0], 1'b0};
						dcnt_q <= dcnt_q + 6'd1;
					end
				end
				ST_DONE: begin
					if (fire) begin
						out_q.result_action <= j_q.idx;
						out_q.is_down       <= down_n;
						out_q.went_down     <= down_n && !prev_rd;
						out_q.went_up       <= !down_n && prev_rd;
						out_q.axis_value    <= sat16(oa);
						out_q.vector_x      <= sat16(ox);
						out_q.vector_y      <= sat16(oy);
						st_q                <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// previous-down store: clear pass, read in ST_DIV1, write with the result
	always_ff @(posedge clk) begin
		if (clr_busy_q) prev_mem[clr_idx_q] <= 1'b0;
		else if (fire && in_rng) prev_mem[pidx] <= down_n;
		if (st_q == ST_DIV1) prev_rd_q <= prev_mem[pidx];
	end

	// shape by action kind
	always_comb begin
		prev_rd = in_rng ? prev_rd_q : 1'b0;
		down_n  = j_q.down;
		oa = '0;
		ox = '0;
		oy = '0;
		case (j_q.kind)
			KIND_BUTTON: oa = j_q.down ? 25'sd32767 : 25'sd0;
			KIND_AXIS: begin
				oa = j_q.axis[23] ? -25'(amt_q) : 25'(amt_q);
				ox = oa;
				down_n = amt_q >= 17'd16384;
			end
			KIND_VECTOR: begin
				ox = j_q.vx[23] ? -25'(mx_q) : 25'(mx_q);
				oy = j_q.vy[23] ? -25'(my_q) : 25'(my_q);
				down_n = amt_q >= 17'd16384;
			end
			default: begin
				oa = 25'(j_q.axis);
				ox = 25'(j_q.vx);
				oy = 25'(j_q.vy);
			end
		endcase
	end

	`IADZ_ASSERT_IMP(a_busy_stalls, clk, arst_n, st_q != ST_IDLE, job_stall, "busy must stall")
	`IADZ_ASSERT_NXT(a_done_out, clk, arst_n, st_q == ST_DONE && !out_stall, ovalid_q, "result lost")
	`IADZ_ASSERT_IMP(a_edges, clk, arst_n, ovalid_q, !(out_q.went_down && out_q.went_up), "both edges")
	`IADZ_ASSERT_NXT(a_out_hold, clk, arst_n, ovalid_q && out_stall, ovalid_q && $stable(out_q), "stalled result changed")
endmodule

// File: rtl/input_action_dead_zone_combiner_unit.sv
// channel | valid     | stall     | payload
// in      | valid     | stall     | in_item  (in_item_t)
// out     | out_valid | out_stall | out_item (out_item_t)
// a sample that is not last is never stalled and is added into the front sum registers
// a last sample gives its result once the one shared shift-subtract unit has run
// (button, axis, pass-through; a vector also takes the magnitude root); inside the dead zone
// the rescale divide is skipped
// after reset the back clears the previous-down store, then takes jobs
// the front holds one finished action; a second last sample stalls until the back is free
module input_action_dead_zone_combiner_unit #(
	parameter int ACTION_COUNT = iadz_pkg::ActionCountDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  iadz_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output iadz_pkg::out_item_t out_item
);
	import iadz_pkg::*;

	logic job_valid, job_stall;
	job_t job;

	// sums and queue
	iadz_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(valid), .in_stall(stall),
		.in_item(in_item), .job_valid(job_valid), .job_stall(job_stall), .job(job)
	);

	// shaping and edges
	iadz_back #(.ACTION_COUNT(ACTION_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_stall(job_stall),
		.job(job), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);
endmodule
